// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define FEST_ASSERT_HOLDS(lbl, clock, rst_n, prop, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define FEST_ASSERT_NEXT(lbl, clock, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/fest_pkg.sv
// ---------------------------------------------------------------------------
// fest_pkg
// Types, codes and constants shared by the servo tracker modules.
// ---------------------------------------------------------------------------
package fest_pkg;

	localparam int unsigned PERIOD_TICKS_DEF = 20;
	localparam int unsigned STALE_MS_DEF     = 250;

	localparam int GAIN_W  = 10;
	localparam int LIMIT_W = 10;
	localparam int US_W    = 15;
	localparam int PULSE_W = 19;
	localparam int SMOOTH_W = 25;
	localparam int ERR_W   = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] MODE_BYTE   = 2'd0;
	localparam logic [1:0] MODE_TICK   = 2'd1;
	localparam logic [1:0] MODE_RESYNC = 2'd2;

	localparam logic [1:0] FS_NONE = 2'd0;
	localparam logic [1:0] FS_OK   = 2'd1;
	localparam logic [1:0] FS_BAD  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_PAN_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PAN_HIGH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_LOW   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_HIGH  = 3'd7;

	localparam logic [GAIN_W-1:0]  PAN_GAIN_RST   = 10'd51;
	localparam logic [GAIN_W-1:0]  TILT_GAIN_RST  = 10'd46;
	localparam logic [LIMIT_W-1:0] PAN_LIMIT_RST  = 10'd60;
	localparam logic [LIMIT_W-1:0] TILT_LIMIT_RST = 10'd50;
	localparam logic [US_W-1:0]    PAN_LOW_RST    = 15'd700;
	localparam logic [US_W-1:0]    PAN_HIGH_RST   = 15'd2300;
	localparam logic [US_W-1:0]    TILT_LOW_RST   = 15'd400;
	localparam logic [US_W-1:0]    TILT_HIGH_RST  = 15'd2200;

	localparam logic [PULSE_W-1:0] PAN_HOME_Q4  = 19'd24000;
	localparam logic [PULSE_W-1:0] TILT_HOME_Q4 = 19'd6400;

	localparam logic [7:0] HDR0      = 8'hAA;
	localparam logic [7:0] HDR1      = 8'h55;
	localparam logic [7:0] FRAME_LEN = 8'h04;

	localparam logic signed [SMOOTH_W-1:0] DEADBAND_Q8 = 25'sd5120;

	typedef struct packed {
		logic accept;
		logic filt;
		logic smth;
		logic mult;
		logic step;
		logic move;
		logic load_out;
		logic axis;
	} fest_cmd_t;

	typedef struct packed {
		logic go;
	} fest_sts_t;

endpackage

// File: sv/framed_error_servo_tracker_unit.sv
// ---------------------------------------------------------------------------
// framed_error_servo_tracker_unit
// Deframes error packets and runs a filtered proportional pan/tilt servo step.
// ---------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         tdata: rx_byte; tuser: mode
// m_axis    out        tdata: pan and tilt pulse widths; tuser: status flags
// cfg       in         one register write per cycle while cfg_write is high
//
// A word with no control step goes from idle to the emit state that loads
// the output register. A control step first runs filter, smooth, multiply,
// step and move for each axis in turn in the shared filter, multiplier and
// clamp unit. The output register lets the next word be accepted while a
// result waits. Reset homes the parser, timers and pulses, not filter state.
// ---------------------------------------------------------------------------
module framed_error_servo_tracker_unit import fest_pkg::*; #(
	parameter int unsigned CONTROL_PERIOD_TICKS = PERIOD_TICKS_DEF,
	parameter int unsigned STALE_AFTER_MS       = STALE_MS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,  // [7:0] rx_byte
	input  logic [1:0]           s_axis_tuser,  // [1:0] mode
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,  // [14:0] pan width us, [29:15] tilt width us
	output logic [3:0]           m_axis_tuser,  // [1:0] frame_status, [2] control_ran,
	                                            // [3] link_lost
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [US_W-1:0]      cfg_data
);

	fest_cmd_t cmd;
	fest_sts_t sts;

	fest_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fest_datapath #(
		.CONTROL_PERIOD_TICKS (CONTROL_PERIOD_TICKS),
		.STALE_AFTER_MS       (STALE_AFTER_MS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_mode   (s_axis_tuser),
		.in_byte   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

// File: sv/fest_datapath.sv
// ---------------------------------------------------------------------------
// fest_datapath
// Packet deframer, link timing, error filter and pulse update for both axes.
// ---------------------------------------------------------------------------
module fest_datapath import fest_pkg::*; #(
	parameter int unsigned CONTROL_PERIOD_TICKS = PERIOD_TICKS_DEF,
	parameter int unsigned STALE_AFTER_MS       = STALE_MS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [US_W-1:0]      cfg_data,
	input  logic [1:0]           in_mode,
	input  logic [7:0]           in_byte,
	input  fest_cmd_t            cmd,
	output fest_sts_t            sts,
	output logic [31:0]          out_data,
	output logic [3:0]           out_user
);

	localparam logic [2:0] PH_AA  = 3'd0;
	localparam logic [2:0] PH_55  = 3'd1;
	localparam logic [2:0] PH_LEN = 3'd2;
	localparam logic [2:0] PH_PAY = 3'd3;
	localparam logic [2:0] PH_SUM = 3'd4;

	localparam logic [4:0] PERIOD    = 5'(CONTROL_PERIOD_TICKS);
	localparam logic [8:0] STALE_LIM = 9'(STALE_AFTER_MS);
	localparam logic [8:0] AGE_MAX   = 9'(STALE_AFTER_MS + 1);

	logic [GAIN_W-1:0]  pan_gain_q, tilt_gain_q;
	logic [LIMIT_W-1:0] pan_limit_q, tilt_limit_q;
	logic [US_W-1:0]    pan_low_q, pan_high_q, tilt_low_q, tilt_high_q;

	logic [2:0] phase_q;
	logic [2:0] pay_idx_q;
	logic [7:0] xor_q;
	logic [7:0] pay_q [4];
	logic signed [ERR_W-1:0] err_x_q, err_y_q;
	logic       fresh_q;
	logic [8:0] age_q;
	logic [4:0] period_q;
	logic       stale_q;
	logic       reseed_q;
	logic signed [SMOOTH_W-1:0] smooth_x_q, smooth_y_q;
	logic [PULSE_W-1:0] pan_q, tilt_q;
	logic [1:0] fstat_q;
	logic       ran_q;

	logic signed [33:0] acc_s1;
	logic signed [35:0] prod_s2;
	logic               move_s2;
	logic signed [15:0] step_s3;

	logic       byte_in, tick_in;
	logic [8:0] age_next;
	logic [4:0] period_inc;
	logic       period_wrap, link_ok;
	logic       frame_ok, pay_we;

	logic signed [SMOOTH_W-1:0] s_sel, smooth_new, seed;
	logic signed [ERR_W-1:0]    raw_sel;
	logic [GAIN_W-1:0]          gain_sel;
	logic [LIMIT_W-1:0]         lim_sel;
	logic [US_W-1:0]            lo_sel, hi_sel;
	logic [PULSE_W-1:0]         pulse_sel, pulse_new;
	logic signed [33:0]         filt_old, filt_new, acc_rnd;
	logic signed [35:0]         prod_rnd;
	logic signed [23:0]         step_raw, lim_pos, lim_neg;
	logic signed [20:0]         sum, lo_ext, hi_ext;

	assign byte_in     = (in_mode == MODE_BYTE);
	assign tick_in     = (in_mode == MODE_TICK);
	assign age_next    = (age_q < AGE_MAX) ? age_q + 9'd1 : age_q;
	assign period_inc  = period_q + 5'd1;
	assign period_wrap = (period_inc >= PERIOD);
	assign link_ok     = (age_next <= STALE_LIM);
	assign sts.go      = tick_in && period_wrap && link_ok && fresh_q;
	assign frame_ok    = cmd.accept && byte_in && (phase_q == PH_SUM) && (in_byte == xor_q);
	assign pay_we      = cmd.accept && byte_in && (phase_q == PH_PAY);

	always_comb begin
		s_sel     = cmd.axis ? smooth_y_q : smooth_x_q;
		raw_sel   = cmd.axis ? err_y_q : err_x_q;
		gain_sel  = cmd.axis ? tilt_gain_q : pan_gain_q;
		lim_sel   = cmd.axis ? tilt_limit_q : pan_limit_q;
		lo_sel    = cmd.axis ? tilt_low_q : pan_low_q;
		hi_sel    = cmd.axis ? tilt_high_q : pan_high_q;
		pulse_sel = cmd.axis ? tilt_q : pan_q;

		filt_old   = {{9{s_sel[SMOOTH_W-1]}}, s_sel} * 34'sd38;
		filt_new   = ({{18{raw_sel[ERR_W-1]}}, raw_sel} * 34'sd218) <<< 8;
		acc_rnd    = acc_s1 + 34'sd128;
		smooth_new = acc_rnd[32:8];
		seed       = {raw_sel[ERR_W-1], raw_sel, 8'd0};

		prod_rnd = prod_s2 + 36'sd2048;
		step_raw = prod_rnd[35:12];
		lim_pos  = $signed({10'd0, lim_sel, 4'd0});
		lim_neg  = -lim_pos;

		sum    = $signed({2'b00, pulse_sel}) + {{5{step_s3[15]}}, step_s3};
		lo_ext = $signed({2'b00, lo_sel, 4'd0});
		hi_ext = $signed({2'b00, hi_sel, 4'd0});
		priority if (sum < lo_ext) begin
			pulse_new = lo_ext[PULSE_W-1:0];
		end else if (sum > hi_ext) begin
			pulse_new = hi_ext[PULSE_W-1:0];
		end else begin
			pulse_new = sum[PULSE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_gain_q   <= PAN_GAIN_RST;
			tilt_gain_q  <= TILT_GAIN_RST;
			pan_limit_q  <= PAN_LIMIT_RST;
			tilt_limit_q <= TILT_LIMIT_RST;
			pan_low_q    <= PAN_LOW_RST;
			pan_high_q   <= PAN_HIGH_RST;
			tilt_low_q   <= TILT_LOW_RST;
			tilt_high_q  <= TILT_HIGH_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_PAN_GAIN:   pan_gain_q   <= cfg_data[GAIN_W-1:0];
				REG_TILT_GAIN:  tilt_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_PAN_LIMIT:  pan_limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_TILT_LIMIT: tilt_limit_q <= cfg_data[LIMIT_W-1:0];
				REG_PAN_LOW:    pan_low_q    <= cfg_data;
				REG_PAN_HIGH:   pan_high_q   <= cfg_data;
				REG_TILT_LOW:   tilt_low_q   <= cfg_data;
				REG_TILT_HIGH:  tilt_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_AA;
			pay_idx_q <= 3'd0;
			xor_q     <= 8'd0;
			fresh_q   <= 1'b0;
			age_q     <= AGE_MAX;
			period_q  <= 5'd0;
			stale_q   <= 1'b1;
			reseed_q  <= 1'b0;
			fstat_q   <= FS_NONE;
			ran_q     <= 1'b0;
			pan_q     <= PAN_HOME_Q4;
			tilt_q    <= TILT_HOME_Q4;
		end else begin
			if (cmd.accept) begin
				if (byte_in && (phase_q == PH_SUM)) begin
					fstat_q <= frame_ok ? FS_OK : FS_BAD;
				end else begin
					fstat_q <= FS_NONE;
				end
				ran_q <= sts.go;
				unique case (in_mode)
					MODE_BYTE: begin
						unique case (phase_q)
							PH_AA: begin
								if (in_byte == HDR0) begin
									phase_q <= PH_55;
								end
							end
							PH_55: begin
								if (in_byte == HDR1) begin
									phase_q <= PH_LEN;
								end else begin
									phase_q <= (in_byte == HDR0) ? PH_55 : PH_AA;
								end
							end
							PH_LEN: begin
								if (in_byte == FRAME_LEN) begin
									pay_idx_q <= 3'd0;
									xor_q     <= in_byte;
									phase_q   <= PH_PAY;
								end else begin
									phase_q <= (in_byte == HDR0) ? PH_55 : PH_AA;
								end
							end
							PH_PAY: begin
								xor_q     <= xor_q ^ in_byte;
								pay_idx_q <= pay_idx_q + 3'd1;
								if (pay_idx_q + 3'd1 >= 3'd4) begin
									phase_q <= PH_SUM;
								end
							end
							PH_SUM: begin
								if (frame_ok) begin
									age_q   <= 9'd0;
									fresh_q <= 1'b1;
								end
								phase_q <= PH_AA;
							end
							default: phase_q <= PH_AA;
						endcase
					end
					MODE_TICK: begin
						age_q    <= age_next;
						period_q <= period_wrap ? 5'd0 : period_inc;
						if (period_wrap) begin
							fresh_q <= 1'b0;
							if (!link_ok) begin
								stale_q <= 1'b1;
							end else if (fresh_q) begin
								reseed_q <= stale_q;
								stale_q  <= 1'b0;
							end
						end
					end
					MODE_RESYNC: phase_q <= PH_AA;
					default: ;
				endcase
			end
			if (cmd.move) begin
				if (cmd.axis) begin
					tilt_q <= pulse_new;
				end else begin
					pan_q <= pulse_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_q[pay_idx_q[1:0]] <= in_byte;
		end
		if (frame_ok) begin
			err_x_q <= $signed({pay_q[1], pay_q[0]});
			err_y_q <= $signed({pay_q[3], pay_q[2]});
		end
		if (cmd.filt) begin
			acc_s1 <= filt_old + filt_new;
		end
		if (cmd.smth) begin
			if (cmd.axis) begin
				smooth_y_q <= reseed_q ? seed : smooth_new;
			end else begin
				smooth_x_q <= reseed_q ? seed : smooth_new;
			end
		end
		if (cmd.mult) begin
			prod_s2 <= $signed({1'b0, gain_sel}) * s_sel;
			move_s2 <= (s_sel > DEADBAND_Q8) || (s_sel < -DEADBAND_Q8);
		end
		if (cmd.step) begin
			priority if (!move_s2) begin
				step_s3 <= 16'sd0;
			end else if (step_raw > lim_pos) begin
				step_s3 <= lim_pos[15:0];
			end else if (step_raw < lim_neg) begin
				step_s3 <= lim_neg[15:0];
			end else begin
				step_s3 <= step_raw[15:0];
			end
		end
		if (cmd.load_out) begin
			out_data <= {2'b00, tilt_q[PULSE_W-1:4], pan_q[PULSE_W-1:4]};
			out_user <= {stale_q, ran_q, fstat_q};
		end
	end

endmodule

// File: sv/fest_ctrl.sv
// ---------------------------------------------------------------------------
// fest_ctrl
// Sequencer that steps the shared axis datapath and owns the stream handshake.
// ---------------------------------------------------------------------------
module fest_ctrl import fest_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  fest_sts_t sts,
	output fest_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FILT = 3'd1;
	localparam logic [2:0] S_SMTH = 3'd2;
	localparam logic [2:0] S_MULT = 3'd3;
	localparam logic [2:0] S_STEP = 3'd4;
	localparam logic [2:0] S_MOVE = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0] state_q;
	logic       axis_q;
	logic       out_valid_q;
	logic       accept, load;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign load      = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.accept   = accept;
		cmd.filt     = (state_q == S_FILT);
		cmd.smth     = (state_q == S_SMTH);
		cmd.mult     = (state_q == S_MULT);
		cmd.step     = (state_q == S_STEP);
		cmd.move     = (state_q == S_MOVE);
		cmd.load_out = load;
		cmd.axis     = axis_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						axis_q  <= 1'b0;
						state_q <= sts.go ? S_FILT : S_EMIT;
					end
				end
				S_FILT: state_q <= S_SMTH;
				S_SMTH: state_q <= S_MULT;
				S_MULT: state_q <= S_STEP;
				S_STEP: state_q <= S_MOVE;
				S_MOVE: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= S_FILT;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sv/fest_checker.sv
// ---------------------------------------------------------------------------
// fest_checker
// Port-level checks on the servo tracker, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fest_checker import fest_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser
);

	`FEST_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")
	`FEST_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a word is still at work")
	`FEST_ASSERT_HOLDS(a_status_code, clk, arst_n, !m_axis_tvalid || (m_axis_tuser[1:0] != 2'd3), "undefined frame status")
	`FEST_ASSERT_HOLDS(a_ran_not_lost, clk, arst_n, !m_axis_tvalid || !(m_axis_tuser[2] && m_axis_tuser[3]), "control step reported on a lost link")
	`FEST_ASSERT_HOLDS(a_ran_no_frame, clk, arst_n, !m_axis_tvalid || !m_axis_tuser[2] || (m_axis_tuser[1:0] == FS_NONE), "control step and frame end in one word")

endmodule

bind framed_error_servo_tracker_unit fest_checker u_fest_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
